[design/pcd_pkg.sv]
package pcd_pkg;

  // Field widths
  localparam int CHAR_W      = 8;
  localparam int SUM_W       = 64;
  localparam int DELTA_W     = 35;
  localparam int INDEX_W     = 16;
  localparam int STATUS_W    = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 1;

  // Chunk format
  localparam int CHUNK_BITS  = 5;
  localparam int MAX_CHUNKS  = 7;
  localparam int COUNT_W     = 3;
  localparam logic [CHAR_W-1:0] CHAR_OFFSET = 8'd63;
  localparam logic [CHAR_W-1:0] CHAR_HIGH   = 8'd126;
  localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'd0;

  // Queue between front and back
  localparam int QUEUE_DEPTH_DEFAULT = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_DIGITS = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_POINTS   = 1'd1;
  localparam logic [INDEX_W-1:0]     MAX_POINTS_RESET = 16'hFFFF;

  // Result kinds
  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  // End status codes
  localparam logic [STATUS_W-1:0] STAT_CLEAN    = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_PARTIAL  = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_CHAR = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_OVERLONG = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_LIMIT    = 3'd4;

  // One queued operation for the back part
  typedef struct packed {
    logic                      kind;
    logic [DELTA_W-1:0]        lat_delta;
    logic [DELTA_W-1:0]        lon_delta;
    logic [INDEX_W-1:0]        point_index;
    logic [STATUS_W-1:0]       end_status;
  } queue_entry_t;

  // Queue occupancy flags
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[design/pcd_front.sv]
module pcd_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [pcd_pkg::CHAR_W-1:0]    char_code,
  input  logic                          cfg_we,
  input  logic [pcd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                          push,
  output pcd_pkg::queue_entry_t         entry
);
  import pcd_pkg::*;

  localparam int VALUE_W = CHUNK_BITS * MAX_CHUNKS;

  logic [INDEX_W-1:0]  max_points;
  logic [VALUE_W-1:0]  chunk_value, chunk_value_next;
  logic [COUNT_W-1:0]  chunk_count, chunk_count_next;
  logic                second_coord, second_coord_next;
  logic [DELTA_W-1:0]  pending_lat_delta, pending_lat_delta_next;
  logic [INDEX_W-1:0]  points_done, points_done_next;
  logic [STATUS_W-1:0] stop_status, stop_status_next;

  logic [CHAR_W-1:0]   char_off;
  logic [VALUE_W-1:0]  value_merged;
  logic [DELTA_W-2:0]  half;
  logic [DELTA_W-1:0]  delta;

  // Hold the point limit; the scale register is not stored, scaling is left to the consumer
  always_ff @(posedge clk) begin
    if (rst) begin
      max_points <= MAX_POINTS_RESET;
    end else if (cfg_we && cfg_index == REG_MAX_POINTS) begin
      max_points <= cfg_data;
    end
  end

  // Merge the new chunk and zigzag decode the value
  always_comb begin
    char_off     = char_code - CHAR_OFFSET;
    value_merged = chunk_value;
    for (int i = 0; i < MAX_CHUNKS; i++) begin
      if (chunk_count == COUNT_W'(i)) begin
        value_merged[i*CHUNK_BITS +: CHUNK_BITS] = char_off[CHUNK_BITS-1:0];
      end
    end
    half  = value_merged[VALUE_W-1:1];
    delta = value_merged[0] ? ~{1'b0, half} : {1'b0, half};
  end

  // Classify the character and advance decode state
  always_comb begin
    chunk_value_next       = chunk_value;
    chunk_count_next       = chunk_count;
    second_coord_next      = second_coord;
    pending_lat_delta_next = pending_lat_delta;
    points_done_next       = points_done;
    stop_status_next       = stop_status;
    push                   = 1'b0;
    entry.kind             = KIND_POINT;
    entry.lat_delta        = pending_lat_delta;
    entry.lon_delta        = delta;
    entry.point_index      = points_done;
    entry.end_status       = STAT_CLEAN;
    if (accept) begin
      priority if (char_code == CHAR_NUL) begin
        push       = 1'b1;
        entry.kind = KIND_END;
        if (stop_status != STAT_CLEAN) begin
          entry.end_status = stop_status;
        end else if (chunk_count != '0 || second_coord) begin
          entry.end_status = STAT_PARTIAL;
        end
        chunk_value_next       = '0;
        chunk_count_next       = '0;
        second_coord_next      = 1'b0;
        pending_lat_delta_next = '0;
        points_done_next       = '0;
        stop_status_next       = STAT_CLEAN;
      end else if (stop_status != STAT_CLEAN) begin
        // drop characters after a stop
      end else if (chunk_count == '0 && !second_coord && points_done >= max_points) begin
        stop_status_next = STAT_LIMIT;
      end else if (chunk_count >= COUNT_W'(MAX_CHUNKS)) begin
        stop_status_next = STAT_OVERLONG;
      end else if (char_code < CHAR_OFFSET || char_code > CHAR_HIGH) begin
        stop_status_next = STAT_BAD_CHAR;
      end else if (char_off[CHUNK_BITS]) begin
        chunk_value_next = value_merged;
        chunk_count_next = chunk_count + 1'b1;
      end else begin
        chunk_value_next = '0;
        chunk_count_next = '0;
        if (!second_coord) begin
          pending_lat_delta_next = delta;
          second_coord_next      = 1'b1;
        end else begin
          push                   = 1'b1;
          pending_lat_delta_next = '0;
          second_coord_next      = 1'b0;
          points_done_next       = points_done + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_value       <= '0;
      chunk_count       <= '0;
      second_coord      <= 1'b0;
      pending_lat_delta <= '0;
      points_done       <= '0;
      stop_status       <= STAT_CLEAN;
    end else begin
      chunk_value       <= chunk_value_next;
      chunk_count       <= chunk_count_next;
      second_coord      <= second_coord_next;
      pending_lat_delta <= pending_lat_delta_next;
      points_done       <= points_done_next;
      stop_status       <= stop_status_next;
    end
  end

`ifndef SYNTH
  a_point_only_active: assert property (@(posedge clk) disable iff (rst)
    (push && entry.kind == KIND_POINT) |-> (stop_status == STAT_CLEAN && second_coord))
    else $error("point pushed while decoding stopped or without latitude");
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    chunk_count <= COUNT_W'(MAX_CHUNKS))
    else $error("chunk count beyond seven");
`endif

endmodule

[design/pcd_queue.sv]
module pcd_queue #(
  parameter int DEPTH = pcd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pcd_pkg::queue_entry_t  push_entry,
  input  logic                   pop,
  output pcd_pkg::queue_entry_t  head,
  output pcd_pkg::queue_status_t status
);
  import pcd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_entry_t       entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign head         = entries[rd_ptr];
  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!status.full || pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("pop from empty queue");
`endif

endmodule

[design/pcd_back.sv]
module pcd_back (
  input  logic                            clk,
  input  logic                            rst,
  input  pcd_pkg::queue_entry_t           head,
  input  pcd_pkg::queue_status_t          q_status,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            kind,
  output logic signed [pcd_pkg::SUM_W-1:0]  lat_units,
  output logic signed [pcd_pkg::SUM_W-1:0]  lon_units,
  output logic [pcd_pkg::INDEX_W-1:0]     point_index,
  output logic [pcd_pkg::STATUS_W-1:0]    end_status,
  output logic                            last
);
  import pcd_pkg::*;

  logic [SUM_W-1:0] lat_sum, lat_sum_next;
  logic [SUM_W-1:0] lon_sum, lon_sum_next;

  // Take the head when the output register is free or being drained
  assign pop = !q_status.empty && (!out_valid || !out_stall);

  // Accumulate deltas; an end transaction clears the sums
  always_comb begin
    lat_sum_next = lat_sum;
    lon_sum_next = lon_sum;
    if (pop) begin
      if (head.kind == KIND_POINT) begin
        lat_sum_next = lat_sum + {{(SUM_W-DELTA_W){head.lat_delta[DELTA_W-1]}}, head.lat_delta};
        lon_sum_next = lon_sum + {{(SUM_W-DELTA_W){head.lon_delta[DELTA_W-1]}}, head.lon_delta};
      end else begin
        lat_sum_next = '0;
        lon_sum_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lat_sum   <= '0;
      lon_sum   <= '0;
      out_valid <= 1'b0;
    end else begin
      lat_sum <= lat_sum_next;
      lon_sum <= lon_sum_next;
      if (pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop) begin
      kind        <= head.kind;
      point_index <= head.point_index;
      end_status  <= head.end_status;
      last        <= (head.kind == KIND_END);
      if (head.kind == KIND_POINT) begin
        lat_units <= lat_sum_next;
        lon_units <= lon_sum_next;
      end else begin
        lat_units <= lat_sum;
        lon_units <= lon_sum;
      end
    end
  end

`ifndef SYNTH
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == KIND_END) |=> (lat_sum == '0 && lon_sum == '0))
    else $error("sums not cleared after end of string");
`endif

endmodule

[design/polyline_coordinate_decoder.sv]
// Encoded polyline decoder. Feed one byte of the encoded string per transaction on
// char_code; a zero byte ends the string. Each completed latitude/longitude pair
// yields a point result (kind 0) carrying the running sums as integers in units of
// 10^-scale_digits degrees; the end byte yields a summary (kind 1, last 1) with the
// point count and a status. A character is accepted every cycle while the internal
// queue (QUEUE_DEPTH transactions) has room; a result is registered in the queue and
// then in the output register, and a stalled output only backs up the input once
// that queue fills. The rate of one character per cycle is set by the front part,
// which gathers chunks and zigzag decodes in a single step, and by the back part,
// which does both 64-bit accumulations in one step. scale_digits is accepted on the
// configuration port but does not change results; scaling is left to the consumer.
module polyline_coordinate_decoder #(
  parameter int QUEUE_DEPTH = pcd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [pcd_pkg::CHAR_W-1:0]        char_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              kind,
  output logic signed [pcd_pkg::SUM_W-1:0]  lat_units,
  output logic signed [pcd_pkg::SUM_W-1:0]  lon_units,
  output logic [pcd_pkg::INDEX_W-1:0]       point_index,
  output logic [pcd_pkg::STATUS_W-1:0]      end_status,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic [pcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pcd_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pcd_pkg::*;

  queue_entry_t  push_entry;
  queue_entry_t  head;
  queue_status_t q_status;
  logic          push;
  logic          pop;
  logic          accept;

  // Stall input only on a full queue
  assign in_stall = q_status.full;
  assign accept   = in_valid && !in_stall;

  pcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .entry     (push_entry)
  );

  pcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  pcd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .lat_units   (lat_units),
    .lon_units   (lon_units),
    .point_index (point_index),
    .end_status  (end_status),
    .last        (last)
  );

endmodule
